@@ rtl/fanmon_pkg.sv @@
// fanmon_pkg: shared types and constants of the fan pwm and tach rpm monitor
// no dependencies; imported by every module of the block

package fanmon_pkg;

  localparam int FAN_PORTS = 2;
  localparam int WIN_W     = 16;
  localparam int PWR_W     = 17;
  localparam int FS_W      = 16;
  localparam int PER_W     = 16;
  localparam int RPM_W     = 24;
  localparam int STEP_W    = $clog2(RPM_W);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [PER_W-1:0] Q15_ONE = 16'h8000;

  // input item kinds
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_POWER = 1'b1;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_PWM_FULL_SCALE = 2'd1,
    REG_RPM_NUMERATOR  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_SAVE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [WIN_W-1:0] window_length;
    logic [FS_W-1:0]  pwm_full_scale;
    logic [RPM_W-1:0] rpm_numerator;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic div_save;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic window_close;
    logic div_last;
    logic last_fan;
  } sts_t;

endpackage

@@ rtl/fanmon_regs.sv @@
// fanmon_regs: apb-style register file holding window length, pwm full scale
// and rpm numerator; depends on fanmon_pkg

module fanmon_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fanmon_pkg::ADDR_W-1:0] paddr,
  input  logic [fanmon_pkg::DATA_W-1:0] pwdata,
  output logic [fanmon_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output fanmon_pkg::cfg_t             cfg_o
);
  import fanmon_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_WINDOW_LENGTH:  cfg_d.window_length  = pwdata[WIN_W-1:0];
        REG_PWM_FULL_SCALE: cfg_d.pwm_full_scale = pwdata[FS_W-1:0];
        REG_RPM_NUMERATOR:  cfg_d.rpm_numerator  = pwdata[RPM_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_LENGTH:  prdata = DATA_W'(cfg_q.window_length);
      REG_PWM_FULL_SCALE: prdata = DATA_W'(cfg_q.pwm_full_scale);
      REG_RPM_NUMERATOR:  prdata = DATA_W'(cfg_q.rpm_numerator);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length  <= 16'd24999;
      cfg_q.pwm_full_scale <= 16'd2500;
      cfg_q.rpm_numerator  <= 24'd3000000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/fanmon_ctrl.sv @@
// fanmon_ctrl: sequencer of the fan monitor, steps the datapath through
// capture, per-fan rpm division and result load; depends on fanmon_pkg

module fanmon_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  fanmon_pkg::sts_t  sts_i,
  output fanmon_pkg::cmd_t  cmd_o
);
  import fanmon_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.window_close ? ST_DIV_INIT : ST_LOAD;
        end
      end
      ST_DIV_INIT: state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (sts_i.div_last) begin
          state_d = ST_DIV_SAVE;
        end
      end
      ST_DIV_SAVE: state_d = sts_i.last_fan ? ST_LOAD : ST_DIV_INIT;
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:     cmd_o.accept   = in_valid_i;
      ST_DIV_INIT: cmd_o.div_load = 1'b1;
      ST_DIV_RUN:  cmd_o.div_step = 1'b1;
      ST_DIV_SAVE: cmd_o.div_save = 1'b1;
      ST_LOAD:     cmd_o.load_out = out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/fanmon_dp.sv @@
// fanmon_dp: power clamp and compare scaling, tach capture lanes, window
// counter, shared restoring rpm divider and result registers; uses fanmon_pkg

module fanmon_dp #(
  parameter int CAPTURE_DEPTH = 3,
  parameter int FAN_COUNT     = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fanmon_pkg::cfg_t                       cfg_i,
  input  fanmon_pkg::cmd_t                       cmd_i,
  output fanmon_pkg::sts_t                       sts_o,
  input  logic                                   action_i,
  input  logic signed [fanmon_pkg::PWR_W-1:0]    power_i,
  input  logic [fanmon_pkg::FAN_PORTS-1:0]       edge_i,
  output logic [fanmon_pkg::PER_W-1:0]           pwm_compare_o,
  output logic                                   fan_enable_o,
  output logic                                   window_done_o,
  output logic [fanmon_pkg::PER_W-1:0]           period_o [fanmon_pkg::FAN_PORTS],
  output logic [fanmon_pkg::RPM_W-1:0]           rpm_o [fanmon_pkg::FAN_PORTS]
);
  import fanmon_pkg::*;

  localparam int LANES  = (FAN_COUNT < FAN_PORTS) ? FAN_COUNT : FAN_PORTS;
  localparam int FIDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CIDX_W = $clog2(CAPTURE_DEPTH);
  localparam int CCNT_W = $clog2(CAPTURE_DEPTH + 1);

  logic                take_tick, take_power;
  logic [WIN_W-1:0]    win_cnt_q;
  logic [PER_W-1:0]    stored_power_q, compare_q, pwr_clamp;
  logic [31:0]         product;
  logic                done_pend_q;
  logic [FIDX_W-1:0]   fan_idx_q;
  logic [RPM_W-1:0]    quot_q;
  logic [PER_W:0]      rem_q, rem_sh, rem_sub;
  logic [STEP_W-1:0]   step_q;
  logic [PER_W-1:0]    per_sel;
  logic [PER_W-1:0]    per_w [LANES];
  logic [RPM_W-1:0]    rpm_w [LANES];
  logic [PER_W-1:0]    out_cmp_q;
  logic                out_en_q, out_done_q;

  assign take_tick  = cmd_i.accept && (action_i == ACT_TICK);
  assign take_power = cmd_i.accept && (action_i == ACT_POWER);

  assign sts_o.window_close = (action_i == ACT_TICK) && (win_cnt_q >= cfg_i.window_length);
  assign sts_o.div_last     = (step_q == STEP_W'(RPM_W - 1));
  assign sts_o.last_fan     = (fan_idx_q == FIDX_W'(LANES - 1));

  // negative power clamps to zero, above one clamps to one
  always_comb begin
    if (power_i[PWR_W-1]) begin
      pwr_clamp = '0;
    end else if (power_i[PER_W-1:0] > Q15_ONE) begin
      pwr_clamp = Q15_ONE;
    end else begin
      pwr_clamp = power_i[PER_W-1:0];
    end
  end

  assign product = 32'(pwr_clamp) * 32'(cfg_i.pwm_full_scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_power_q <= '0;
      compare_q      <= '0;
      win_cnt_q      <= '0;
      done_pend_q    <= 1'b0;
      fan_idx_q      <= '0;
    end else begin
      if (take_power) begin
        stored_power_q <= pwr_clamp;
        compare_q      <= product[30:15];
      end
      if (take_tick) begin
        win_cnt_q <= sts_o.window_close ? '0 : win_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        done_pend_q <= take_tick && sts_o.window_close;
        fan_idx_q   <= '0;
      end else if (cmd_i.div_save) begin
        fan_idx_q <= sts_o.last_fan ? '0 : fan_idx_q + 1'b1;
      end
    end
  end

  // tach capture lanes
  for (genvar f = 0; f < LANES; f++) begin : g_lane
    logic [WIN_W-1:0]  caps_q [CAPTURE_DEPTH];
    logic [WIN_W-1:0]  caps_d [CAPTURE_DEPTH];
    logic [CCNT_W-1:0] cnt_q, cnt_d;
    logic [PER_W-1:0]  per_q, per_d;
    logic [RPM_W-1:0]  rpm_q;

    always_comb begin
      caps_d = caps_q;
      cnt_d  = cnt_q;
      per_d  = per_q;
      if (take_tick) begin
        if (edge_i[f] && (cnt_q < CCNT_W'(CAPTURE_DEPTH))) begin
          caps_d[cnt_q[CIDX_W-1:0]] = win_cnt_q;
          cnt_d = cnt_q + 1'b1;
        end
        // period from the last two capture slots, taken after this tick's edge
        if (sts_o.window_close) begin
          per_d = (caps_d[CAPTURE_DEPTH-1] > caps_d[CAPTURE_DEPTH-2]) ?
                  (caps_d[CAPTURE_DEPTH-1] - caps_d[CAPTURE_DEPTH-2]) : '0;
          cnt_d = '0;
          caps_d[CAPTURE_DEPTH-1] = '0;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < CAPTURE_DEPTH; i++) begin
          caps_q[i] <= '0;
        end
        cnt_q <= '0;
        per_q <= '0;
        rpm_q <= '0;
      end else begin
        caps_q <= caps_d;
        cnt_q  <= cnt_d;
        per_q  <= per_d;
        if (cmd_i.div_save && (fan_idx_q == FIDX_W'(f))) begin
          rpm_q <= (per_q == '0) ? '0 : quot_q;
        end
      end
    end

    assign per_w[f] = per_q;
    assign rpm_w[f] = rpm_q;
  end

  // restoring divider, one quotient bit per cycle
  assign per_sel = per_w[fan_idx_q];
  assign rem_sh  = {rem_q[PER_W-1:0], quot_q[RPM_W-1]};
  assign rem_sub = rem_sh - {1'b0, per_sel};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quot_q <= cfg_i.rpm_numerator;
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, per_sel}) begin
        rem_q  <= rem_sub;
        quot_q <= {quot_q[RPM_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[RPM_W-2:0], 1'b0};
      end
      step_q <= step_q + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cmp_q  <= compare_q;
      out_en_q   <= (stored_power_q != '0);
      out_done_q <= done_pend_q;
    end
  end

  assign pwm_compare_o = out_cmp_q;
  assign fan_enable_o  = out_en_q;
  assign window_done_o = out_done_q;

  for (genvar f = 0; f < FAN_PORTS; f++) begin : g_port
    if (f < LANES) begin : g_used
      logic [PER_W-1:0] out_per_q;
      logic [RPM_W-1:0] out_rpm_q;
      always_ff @(posedge clk_i) begin
        if (cmd_i.load_out) begin
          out_per_q <= per_w[f];
          out_rpm_q <= rpm_w[f];
        end
      end
      assign period_o[f] = out_per_q;
      assign rpm_o[f]    = out_rpm_q;
    end else begin : g_absent
      assign period_o[f] = '0;
      assign rpm_o[f]    = '0;
    end
  end

endmodule

@@ rtl/fan_pwm_and_tach_rpm_monitor.sv @@
// Fan controller with pwm power setting and tachometer rpm monitor. A power
// request or a tick request that does not end a window goes from the idle
// state through the load state into the output registers. A tick that ends
// the measurement window runs one shared restoring divider over the fans in
// turn, each with a load, 24 quotient bit steps and a store, and then goes
// through the load state too. One request is in flight at a time; the next
// is taken as soon as the previous result sits in the output register, even
// while that result is still stalled. Registers are written over the apb
// port at byte addresses 0, 4 and 8 by the user only while the block is
// idle; the block itself does not enforce this.
// Depends on fanmon_pkg, fanmon_regs, fanmon_ctrl and fanmon_dp.

module fan_pwm_and_tach_rpm_monitor #(
  parameter int CAPTURE_DEPTH = 3,
  parameter int FAN_COUNT     = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fanmon_pkg::ADDR_W-1:0]       paddr,
  input  logic [fanmon_pkg::DATA_W-1:0]       pwdata,
  output logic [fanmon_pkg::DATA_W-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [fanmon_pkg::PWR_W-1:0] power_i,
  input  logic                                edge_one_i,
  input  logic                                edge_two_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fanmon_pkg::PER_W-1:0]        pwm_compare_o,
  output logic                                fan_enable_o,
  output logic                                window_done_o,
  output logic [fanmon_pkg::PER_W-1:0]        period_one_o,
  output logic [fanmon_pkg::PER_W-1:0]        period_two_o,
  output logic [fanmon_pkg::RPM_W-1:0]        rpm_one_o,
  output logic [fanmon_pkg::RPM_W-1:0]        rpm_two_o
);
  import fanmon_pkg::*;

  cfg_t                 cfg;
  cmd_t                 cmd;
  sts_t                 sts;
  logic [PER_W-1:0]     period [FAN_PORTS];
  logic [RPM_W-1:0]     rpm [FAN_PORTS];

  fanmon_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fanmon_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fanmon_dp #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .FAN_COUNT     (FAN_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .power_i       (power_i),
    .edge_i        ({edge_two_i, edge_one_i}),
    .pwm_compare_o (pwm_compare_o),
    .fan_enable_o  (fan_enable_o),
    .window_done_o (window_done_o),
    .period_o      (period),
    .rpm_o         (rpm)
  );

  assign period_one_o = period[0];
  assign period_two_o = period[1];
  assign rpm_one_o    = rpm[0];
  assign rpm_two_o    = rpm[1];

endmodule

@@ rtl/fanmon_checker.sv @@
// fanmon_checker: port-level checks of the fan monitor over time, bound to
// the top level; depends on fanmon_pkg and fan_pwm_and_tach_rpm_monitor

module fanmon_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                action_i,
  input logic signed [fanmon_pkg::PWR_W-1:0] power_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                fan_enable_o,
  input logic                                window_done_o,
  input logic [fanmon_pkg::PER_W-1:0]        period_one_o,
  input logic [fanmon_pkg::PER_W-1:0]        period_two_o,
  input logic [fanmon_pkg::RPM_W-1:0]        rpm_one_o,
  input logic [fanmon_pkg::RPM_W-1:0]        rpm_two_o
);
  import fanmon_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rpm_one_o))
    else $error("stalled result changed or dropped");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while another is in flight");

  // power request result shows enable from clamped power, no window end
  a_power_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_POWER) && !out_valid_o |=> ##1
      out_valid_o && !window_done_o &&
      (fan_enable_o == (!$past(power_i[PWR_W-1], 2) &&
                        ($past(power_i[PER_W-1:0], 2) != '0))))
    else $error("power result wrong or late");

  // idle fan reports zero speed
  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((period_one_o == '0) || (period_two_o == '0)) |->
      ((period_one_o != '0) || (rpm_one_o == '0)) &&
      ((period_two_o != '0) || (rpm_two_o == '0)))
    else $error("nonzero rpm with zero period");

endmodule

bind fan_pwm_and_tach_rpm_monitor fanmon_checker u_fanmon_checker (.*);
